// ----- src/asrl_pkg.sv -----
package asrl_pkg;

    localparam int unsigned SEG_DEPTH = 256;
    localparam int unsigned SYM_DEPTH = 4096;
    localparam int unsigned SEG_AW = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
    localparam int unsigned SYM_AW = (SYM_DEPTH > 1) ? $clog2(SYM_DEPTH) : 1;
    localparam int unsigned CFG_W = 9;
    // symbol positions reach first_symbol + symbol_count
    localparam int unsigned POS_W = 14;
    localparam logic [31:0] ADDR_CLEAR = 32'hFFFF_FFFE;

    typedef enum logic [1:0] {
        MODE_LOAD_SEG = 2'd0,
        MODE_LOAD_SYM = 2'd1,
        MODE_LOOKUP   = 2'd2,
        MODE_UNUSED   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        K_NONE,
        K_SEG,
        K_SYM,
        K_LOOK
    } t_kind;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] entry_index;
        logic [31:0] address;
        logic [31:0] alt_address;
        logic [31:0] sym_length;
        logic [11:0] first_symbol;
        logic [12:0] symbol_count;
    } t_in;

    typedef struct packed {
        logic        segment_hit;
        logic        symbol_hit;
        logic [7:0]  segment_index;
        logic [11:0] symbol_index;
        logic [31:0] base_address;
        logic [31:0] displacement;
    } t_out;

    typedef struct packed {
        t_kind kind;
        t_in   item;
    } t_cmd;

    typedef struct packed {
        logic [31:0] code;
        logic [31:0] data;
        logic [11:0] first;
        logic [12:0] cnt;
    } t_seg;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] len;
    } t_sym;

endpackage

// ----- src/asrl_ram.sv -----
module asrl_ram #(
    parameter int unsigned W = 8,
    parameter int unsigned D = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                         i_wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/asrl_front.sv -----
module asrl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  asrl_pkg::t_in i_item,
    output logic          o_full,
    output logic          o_cmd_valid,
    output asrl_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);
    import asrl_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_cmd       cmd_in;
    logic       acc, pop;

    always_comb begin
        cmd_in.item = i_item;
        case (t_mode'(i_item.mode))
            MODE_LOAD_SEG: begin
                cmd_in.kind = (32'(i_item.entry_index) < SEG_DEPTH) ? K_SEG : K_NONE;
            end
            MODE_LOAD_SYM: begin
                cmd_in.kind = (32'(i_item.entry_index) < SYM_DEPTH) ? K_SYM : K_NONE;
            end
            MODE_LOOKUP: begin
                cmd_in.kind = K_LOOK;
            end
            default: begin
                cmd_in.kind = K_NONE;
            end
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign acc         = i_push && !o_full;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wp  = acc ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, acc} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (acc) begin
            r_q[r_wp] <= cmd_in;
        end
    end
endmodule

// ----- src/asrl_back.sv -----
module asrl_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  asrl_pkg::t_cmd                    i_cmd,
    output logic                              o_cmd_pop,
    input  logic [asrl_pkg::CFG_W-1:0]        i_seg_count,
    output logic                              o_res_valid,
    output asrl_pkg::t_out                    o_res,
    input  logic                              i_res_pop
);
    import asrl_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SEG_ISS = 9'b000000010,
        S_SEG_CMP = 9'b000000100,
        S_SEG_GET = 9'b000001000,
        S_SPAN    = 9'b000010000,
        S_SYM_ISS = 9'b000100000,
        S_SYM_CMP = 9'b001000000,
        S_SKIP    = 9'b010000000,
        S_FIN     = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    logic [31:0]        r_addr, n_addr;
    logic [POS_W-1:0]   r_lo, n_lo;
    logic [POS_W-1:0]   r_n, n_n;
    logic [POS_W-1:0]   r_mid, n_mid;
    logic [POS_W-1:0]   r_first, n_first;
    logic [POS_W-1:0]   r_end, n_end;
    logic [POS_W-1:0]   r_sym, n_sym;
    logic [SEG_AW-1:0]  r_seg, n_seg;
    logic [31:0]        r_code, n_code;
    logic [31:0]        r_saddr, n_saddr;
    logic [31:0]        r_slen, n_slen;
    logic               r_oob, n_oob;
    logic               r_seg_hit, n_seg_hit;
    logic               r_res_valid, n_res_valid;
    t_out               r_res, n_res;

    logic               seg_we, sym_we;
    logic [SEG_AW-1:0]  seg_raddr;
    logic [SYM_AW-1:0]  sym_raddr;
    t_seg               seg_wdata, seg_rdata;
    t_sym               sym_wdata, sym_rdata, sym_rd;
    logic [POS_W-1:0]   mid, sel, last;
    logic [31:0]        key, span_end, off, soff;
    logic               sym_hit;

    assign seg_wdata = '{code: i_cmd.item.address, data: i_cmd.item.alt_address,
                         first: i_cmd.item.first_symbol, cnt: i_cmd.item.symbol_count};
    assign sym_wdata = '{addr: i_cmd.item.address, len: i_cmd.item.sym_length};

    asrl_ram #(.W($bits(t_seg)), .D(SEG_DEPTH)) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (seg_we),
        .i_waddr (SEG_AW'(i_cmd.item.entry_index)),
        .i_wdata (seg_wdata),
        .i_raddr (seg_raddr),
        .o_rdata (seg_rdata)
    );

    asrl_ram #(.W($bits(t_sym)), .D(SYM_DEPTH)) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (sym_we),
        .i_waddr (SYM_AW'(i_cmd.item.entry_index)),
        .i_wdata (sym_wdata),
        .i_raddr (sym_raddr),
        .o_rdata (sym_rdata)
    );

    // entries past the symbol table read as zero
    assign sym_rd = r_oob ? '0 : sym_rdata;
    assign mid    = r_lo + (r_n >> 1);
    assign key    = (seg_rdata.code != 32'd0) ? seg_rdata.code : seg_rdata.data;
    assign last   = POS_W'(seg_rdata.first) + POS_W'(seg_rdata.cnt) - POS_W'(1);
    assign span_end = sym_rd.addr + sym_rd.len;
    assign off    = r_addr - r_code;
    assign soff   = r_saddr - r_code;
    assign sym_hit = (off >= soff) && (off < soff + r_slen);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_lo        = r_lo;
        n_n         = r_n;
        n_mid       = r_mid;
        n_first     = r_first;
        n_end       = r_end;
        n_sym       = r_sym;
        n_seg       = r_seg;
        n_code      = r_code;
        n_saddr     = r_saddr;
        n_slen      = r_slen;
        n_oob       = r_oob;
        n_seg_hit   = r_seg_hit;
        n_res_valid = r_res_valid && !i_res_pop;
        n_res       = r_res;
        seg_we      = 1'b0;
        sym_we      = 1'b0;
        o_cmd_pop   = 1'b0;
        seg_raddr   = '0;
        sym_raddr   = '0;
        sel         = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        K_SEG: seg_we = 1'b1;
                        K_SYM: sym_we = 1'b1;
                        K_LOOK: begin
                            n_addr    = i_cmd.item.address & ADDR_CLEAR;
                            n_lo      = '0;
                            n_n       = POS_W'(i_seg_count);
                            n_seg_hit = 1'b0;
                            n_state   = (i_seg_count == '0) ? S_FIN : S_SEG_ISS;
                        end
                        default: ;
                    endcase
                end
            end
            S_SEG_ISS: begin
                if (r_n == '0) begin
                    // step back to the last key not above the address
                    sel       = (r_lo != '0) ? r_lo - POS_W'(1) : '0;
                    seg_raddr = SEG_AW'(sel);
                    n_seg     = SEG_AW'(sel);
                    n_state   = S_SEG_GET;
                end else begin
                    seg_raddr = SEG_AW'(mid);
                    n_mid     = mid;
                    n_state   = S_SEG_CMP;
                end
            end
            S_SEG_CMP: begin
                if (r_addr < key) begin
                    n_n = r_n >> 1;
                end else begin
                    n_lo = r_mid + POS_W'(1);
                    n_n  = r_n - (r_n >> 1) - POS_W'(1);
                end
                n_state = S_SEG_ISS;
            end
            S_SEG_GET: begin
                n_code  = seg_rdata.code;
                n_first = POS_W'(seg_rdata.first);
                n_end   = POS_W'(seg_rdata.first) + POS_W'(seg_rdata.cnt);
                n_n     = POS_W'(seg_rdata.cnt);
                if (seg_rdata.cnt == '0) begin
                    n_state = S_FIN;
                end else begin
                    sym_raddr = SYM_AW'(last);
                    n_oob     = 32'(last) >= SYM_DEPTH;
                    n_state   = S_SPAN;
                end
            end
            S_SPAN: begin
                if ((r_addr >= r_code) && (r_addr < span_end)) begin
                    n_seg_hit = 1'b1;
                    n_lo      = r_first;
                    n_state   = S_SYM_ISS;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SYM_ISS: begin
                if (r_n == '0) begin
                    sel       = (r_lo != r_first) ? r_lo - POS_W'(1) : r_lo;
                    sym_raddr = SYM_AW'(sel);
                    n_oob     = 32'(sel) >= SYM_DEPTH;
                    n_sym     = sel;
                    n_state   = S_SKIP;
                end else begin
                    sym_raddr = SYM_AW'(mid);
                    n_oob     = 32'(mid) >= SYM_DEPTH;
                    n_mid     = mid;
                    n_state   = S_SYM_CMP;
                end
            end
            S_SYM_CMP: begin
                if (r_addr < sym_rd.addr) begin
                    n_n = r_n >> 1;
                end else begin
                    n_lo = r_mid + POS_W'(1);
                    n_n  = r_n - (r_n >> 1) - POS_W'(1);
                end
                n_state = S_SYM_ISS;
            end
            S_SKIP: begin
                // walk past zero-length symbols, one read per beat
                if ((sym_rd.len == 32'd0) && (r_sym != r_end)) begin
                    sel       = r_sym + POS_W'(1);
                    sym_raddr = SYM_AW'(sel);
                    n_oob     = 32'(sel) >= SYM_DEPTH;
                    n_sym     = sel;
                end else begin
                    n_saddr = sym_rd.addr;
                    n_slen  = sym_rd.len;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_res_valid) begin
                    n_res = '0;
                    if (r_seg_hit) begin
                        n_res.segment_hit   = 1'b1;
                        n_res.segment_index = 8'(r_seg);
                        if (sym_hit) begin
                            n_res.symbol_hit   = 1'b1;
                            n_res.symbol_index = 12'(r_sym);
                            n_res.base_address = r_saddr;
                            n_res.displacement = r_addr - r_saddr;
                        end else begin
                            n_res.base_address = r_code;
                            n_res.displacement = off;
                        end
                    end
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_seg_hit   <= 1'b0;
            r_oob       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_seg_hit   <= n_seg_hit;
            r_oob       <= n_oob;
        end
        r_addr  <= n_addr;
        r_lo    <= n_lo;
        r_n     <= n_n;
        r_mid   <= n_mid;
        r_first <= n_first;
        r_end   <= n_end;
        r_sym   <= n_sym;
        r_seg   <= n_seg;
        r_code  <= n_code;
        r_saddr <= n_saddr;
        r_slen  <= n_slen;
        r_res   <= n_res;
    end
endmodule

// ----- src/address_to_symbol_range_lookup_top.sv -----
// Address to symbol lookup over a segment table (256 entries) and a symbol table
// (4096 entries), each a single-port-read RAM filled by load beats. The back end
// writes each load into its table. A lookup is a sequence of dependent table reads:
// take the command, then a read and a compare per bisection step over the segments
// (nine steps for 256), a step back to the chosen segment, its read and a test of its
// span, then a read and a compare per bisection step over the segment's symbols
// (thirteen steps for 4096), a read to settle on a symbol plus one more read per
// skipped zero-length symbol, and a last state that registers the result. Each table
// has one read port, so its reads come one after another. A two-entry queue ahead of
// the back end takes up to two more beats, and a result register can be drained,
// while a lookup runs. Tables hold nothing after reset and need no clearing;
// segment_count resets to zero and must be written through the cfg channel only while
// the block is idle; the block itself does not enforce this.
module address_to_symbol_range_lookup_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  asrl_pkg::t_in               i_item,
    output logic                        empty,
    input  logic                        pop,
    output asrl_pkg::t_out              o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [asrl_pkg::CFG_W-1:0]  i_cfg_data
);
    import asrl_pkg::*;

    logic [CFG_W-1:0] r_cfg;
    logic [CFG_W-1:0] eff_count;
    logic             cmd_valid, cmd_pop, res_valid;
    t_cmd             cmd;

    assign o_cfg_ready = 1'b1;
    assign eff_count = (32'(r_cfg) > SEG_DEPTH) ? CFG_W'(SEG_DEPTH) : r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg <= i_cfg_data;
        end
    end

    asrl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    asrl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_seg_count (eff_count),
        .o_res_valid (res_valid),
        .o_res       (o_result),
        .i_res_pop   (pop && !empty)
    );

    assign empty = !res_valid;
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import asrl_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    t_in                i_item;
    logic               empty;
    logic               pop;
    t_out               o_result;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data;

    address_to_symbol_range_lookup_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // local copy of the tables and the segment count
    logic [31:0] m_code [SEG_DEPTH];
    logic [31:0] m_data [SEG_DEPTH];
    logic [11:0] m_first [SEG_DEPTH];
    logic [12:0] m_cnt [SEG_DEPTH];
    bit          seg_set [SEG_DEPTH];
    logic [31:0] m_sym_addr [SYM_DEPTH];
    logic [31:0] m_sym_len [SYM_DEPTH];
    bit          sym_set [SYM_DEPTH];
    int unsigned seg_limit;
    bit          touched_blank;

    t_out        lookups_due[$];
    int          errors;
    int          sent;
    int          calm_tx;
    int          calm_rx;
    int          hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("address_to_symbol_range_lookup_top verification failed");
        $finish;
    end

    function automatic int draw_wait(inout int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            run = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] seg_key_at(int unsigned i);
        if (!seg_set[i]) touched_blank = 1'b1;
        return (m_code[i] != 0) ? m_code[i] : m_data[i];
    endfunction

    function automatic logic [31:0] sym_addr_at(int unsigned i);
        if (i >= SYM_DEPTH) return 32'd0;
        if (!sym_set[i]) touched_blank = 1'b1;
        return m_sym_addr[i];
    endfunction

    function automatic logic [31:0] sym_len_at(int unsigned i);
        if (i >= SYM_DEPTH) return 32'd0;
        if (!sym_set[i]) touched_blank = 1'b1;
        return m_sym_len[i];
    endfunction

    function automatic t_out locate_symbol(logic [31:0] raw);
        logic [31:0] a, code, span_end, off, saddr, slen, soff;
        int unsigned n, lo, half, mid, seg, cnt, first, last, sym, stop;
        t_out r;
        r = '0;
        a = raw & ADDR_CLEAR;
        n = (seg_limit > SEG_DEPTH) ? SEG_DEPTH : seg_limit;
        if (n == 0) return r;
        // upper-bound bisection over the segment keys, then one step back
        lo = 0;
        while (n > 0) begin
            half = n >> 1;
            mid = lo + half;
            if (a < seg_key_at(mid)) n = half;
            else begin
                lo = mid + 1;
                n = n - half - 1;
            end
        end
        seg = (lo > 0) ? lo - 1 : 0;
        if (!seg_set[seg]) touched_blank = 1'b1;
        code = m_code[seg];
        cnt = m_cnt[seg];
        first = m_first[seg];
        if (cnt == 0) return r;
        last = first + cnt - 1;
        span_end = sym_addr_at(last) + sym_len_at(last);
        if (!(a >= code && a < span_end)) return r;
        r.segment_hit = 1'b1;
        r.segment_index = seg[7:0];
        lo = first;
        n = cnt;
        while (n > 0) begin
            half = n >> 1;
            mid = lo + half;
            if (a < sym_addr_at(mid)) n = half;
            else begin
                lo = mid + 1;
                n = n - half - 1;
            end
        end
        sym = (lo != first) ? lo - 1 : lo;
        stop = first + cnt;
        // zero-length symbols are skipped, possibly up to the one past the end
        while (sym_len_at(sym) == 0 && sym != stop) sym++;
        saddr = sym_addr_at(sym);
        slen = sym_len_at(sym);
        off = a - code;
        soff = saddr - code;
        if (off >= soff && off < soff + slen) begin
            r.symbol_hit = 1'b1;
            r.symbol_index = sym[11:0];
            r.base_address = saddr;
        end else begin
            r.base_address = code;
        end
        r.displacement = a - r.base_address;
        return r;
    endfunction

    function automatic void apply_load(t_in it);
        if (it.mode == MODE_LOAD_SEG && it.entry_index < SEG_DEPTH) begin
            m_code[it.entry_index] = it.address;
            m_data[it.entry_index] = it.alt_address;
            m_first[it.entry_index] = it.first_symbol;
            m_cnt[it.entry_index] = it.symbol_count;
            seg_set[it.entry_index] = 1'b1;
        end else if (it.mode == MODE_LOAD_SYM) begin
            m_sym_addr[it.entry_index] = it.address;
            m_sym_len[it.entry_index] = it.sym_length;
            sym_set[it.entry_index] = 1'b1;
        end
    endfunction

    function automatic t_in seg_item(int unsigned idx, logic [31:0] code, logic [31:0] data,
                                     int unsigned first, int unsigned cnt);
        t_in it;
        it = '0;
        it.mode = MODE_LOAD_SEG;
        it.entry_index = idx[11:0];
        it.address = code;
        it.alt_address = data;
        it.first_symbol = first[11:0];
        it.symbol_count = cnt[12:0];
        return it;
    endfunction

    function automatic t_in sym_item(int unsigned idx, logic [31:0] addr, logic [31:0] len);
        t_in it;
        it = '0;
        it.mode = MODE_LOAD_SYM;
        it.entry_index = idx[11:0];
        it.address = addr;
        it.sym_length = len;
        return it;
    endfunction

    task automatic send_item(input t_in it);
        int g;
        g = draw_wait(calm_tx);
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        if (it.mode == MODE_LOOKUP) lookups_due.push_back(locate_symbol(it.address));
        else apply_load(it);
        sent++;
    endtask

    // a lookup that would touch an unwritten table entry is sent as an unused-mode item instead
    task automatic send_lookup(input logic [31:0] addr);
        t_in it;
        t_out unused;
        it = '0;
        touched_blank = 1'b0;
        unused = locate_symbol(addr);
        it.mode = touched_blank ? MODE_UNUSED : MODE_LOOKUP;
        it.address = addr;
        it.alt_address = $urandom;
        it.sym_length = $urandom;
        send_item(it);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (lookups_due.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic write_cfg(input int unsigned v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v[CFG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        seg_limit = v;
    endtask

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
            errors++;
        end
    endfunction

    initial begin
        t_out exp;
        int s;
        pop = 1'b0;
        @(posedge i_clk);
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_cycles > 0) begin
                s = hold_cycles;
                hold_cycles = 0;
            end else begin
                s = draw_wait(calm_rx);
            end
            if (s > 0) begin
                pop <= 1'b0;
                repeat (s) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (lookups_due.size() == 0) begin
                $display("%0t: unexpected result beat, actual %p", $time, o_result);
                errors++;
            end else begin
                exp = lookups_due.pop_front();
                check_field("segment_hit", 32'(exp.segment_hit), 32'(o_result.segment_hit));
                check_field("symbol_hit", 32'(exp.symbol_hit), 32'(o_result.symbol_hit));
                check_field("segment_index", 32'(exp.segment_index),
                            32'(o_result.segment_index));
                check_field("symbol_index", 32'(exp.symbol_index),
                            32'(o_result.symbol_index));
                check_field("base_address", exp.base_address, o_result.base_address);
                check_field("displacement", exp.displacement, o_result.displacement);
            end
        end
    end

    task automatic test_no_segments();
        write_cfg(0);
        send_lookup(32'hFFFF_FFFF);
        send_lookup(32'h0000_0000);
    endtask

    task automatic test_directed();
        t_in it;
        send_item(seg_item(0, 32'h1000, 32'h0, 0, 3));
        send_item(sym_item(0, 32'h1000, 32'h10));
        send_item(sym_item(1, 32'h1010, 32'h0));
        send_item(sym_item(2, 32'h1020, 32'h20));
        send_item(sym_item(3, 32'h2000, 32'h4));
        // code address of zero: data address is the key, no symbols
        send_item(seg_item(1, 32'h0, 32'h8000, 4, 0));
        // span end wraps past 2^32
        send_item(seg_item(2, 32'hFFFF_0000, 32'h1, 5, 1));
        send_item(sym_item(5, 32'hFFFF_FFF0, 32'h20));
        send_item(sym_item(6, 32'hFFFF_FFF8, 32'h8));
        send_item(seg_item(300, 32'hDEAD_BEEF, 32'h0, 4095, 4096));
        it = '1;
        it.mode = MODE_UNUSED;
        send_item(it);
        write_cfg(3);
        send_lookup(32'h0000_0000);
        send_lookup(32'h0000_1001);
        send_lookup(32'h0000_1013);
        send_lookup(32'h0000_1030);
        send_lookup(32'h0000_9000);
        send_lookup(32'hFFFF_0004);
        send_lookup(32'hFFFF_FFFF);
    endtask

    task automatic random_phase(input int unsigned nseg);
        logic [31:0] base, stride, code, step, addr;
        int unsigned cnt, first, s, j;
        bit mixed;
        t_in it;
        base = $urandom;
        stride = $urandom_range(16, 1 << 20);
        mixed = ($urandom_range(0, 5) == 0);
        for (int unsigned i = 0; i < nseg; i++) begin
            code = mixed ? $urandom : base + i * stride;
            cnt = $urandom_range(0, 6);
            first = $urandom_range(0, SYM_DEPTH - cnt);
            step = $urandom_range(2, stride / 8 + 2);
            if ($urandom_range(0, 7) == 0) send_item(seg_item(i, 32'h0, code, first, cnt));
            else send_item(seg_item(i, code, $urandom, first, cnt));
            for (j = 0; j <= cnt; j++) begin
                if (first + j < SYM_DEPTH)
                    send_item(sym_item(first + j, code + j * step,
                        ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, step)));
            end
        end
        write_cfg(($urandom_range(0, 3) == 0) ? $urandom_range(0, nseg) : nseg);
        repeat ($urandom_range(30, 70)) begin
            if ($urandom_range(0, 6) == 0) begin
                it = {$urandom, $urandom, $urandom, $urandom, 7'($urandom)};
                if ($urandom_range(0, 1)) it.symbol_count = 13'($urandom_range(0, 4096));
                if (it.mode == MODE_LOOKUP) send_lookup(it.address);
                else send_item(it);
            end else begin
                s = $urandom_range(0, nseg - 1);
                if (seg_set[s] && m_cnt[s] != 0 && $urandom_range(0, 7) != 0) begin
                    j = m_first[s] + $urandom_range(0, m_cnt[s] - 1);
                    addr = (j < SYM_DEPTH && sym_set[j])
                           ? m_sym_addr[j] + $urandom_range(0, m_sym_len[j] + 2)
                           : m_code[s];
                end else if ($urandom_range(0, 1)) begin
                    addr = m_code[s] + $urandom_range(0, 64);
                end else begin
                    addr = $urandom;
                end
                send_lookup(addr ^ $urandom_range(0, 1));
            end
        end
    endtask

    task automatic test_random();
        while (sent < 1150) random_phase($urandom_range(1, 12));
    endtask

    task automatic test_full_table();
        logic [31:0] code;
        for (int unsigned i = 0; i < SEG_DEPTH; i++) begin
            code = (i << 20) | 32'h100;
            if (i % 32 == 0) begin
                send_item(seg_item(i, code, 32'h0, i / 8, 2));
                send_item(sym_item(i / 8, code, 32'h40));
                send_item(sym_item(i / 8 + 1, code + 32'h80, 32'h0));
                send_item(sym_item(i / 8 + 2, code + 32'h90, 32'h10));
            end else begin
                send_item(seg_item(i, code, $urandom, $urandom_range(0, 4095), 0));
            end
        end
        write_cfg(SEG_DEPTH);
        repeat (40) send_lookup(($urandom_range(0, 7) << 25) | $urandom_range(0, 32'h1FF));
        write_cfg((1 << CFG_W) - 1);
        repeat (20) send_lookup($urandom);
    endtask

    // receiver stalls long enough for the input side to back up
    task automatic test_backpressure();
        settle();
        hold_cycles = 300;
        repeat (24) send_lookup($urandom);
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        seg_limit = 0;
        errors = 0;
        sent = 0;
        calm_tx = 0;
        calm_rx = 0;
        hold_cycles = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_no_segments();
        test_directed();
        test_random();
        test_full_table();
        test_backpressure();
        settle();
        if (errors == 0) $display("address_to_symbol_range_lookup_top verification clean");
        else $display("address_to_symbol_range_lookup_top verification failed");
        $finish;
    end

endmodule
